>>> sv/rea_pkg.sv
// ----------------------------------------------------------------------------
// rea_pkg
// Shared types and constants of the reprojection error accumulator.
// ----------------------------------------------------------------------------
package rea_pkg;

    localparam int MAX_POINTS_DEF = 65536;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int NUM_REGS = 6;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 64;
    localparam int DATA_W   = 32;
    localparam int ERR_W    = 31;
    localparam int SUM_W    = 48;
    // quotient bits of one projection divide (enough to see any overflow)
    localparam int QB       = 34;
    localparam int STEP_W   = 6;

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 224;

    typedef enum logic [1:0] {
        DIV_RX,
        DIV_RY,
        DIV_AX,
        DIV_AY
    } div_op_t;

    typedef struct packed {
        logic       load_in;
        logic       mul;
        logic       acc;
        logic [1:0] row;
        logic [1:0] col;
        logic       div_start;
        logic       div_store;
        div_op_t    div_op;
        logic       err_update;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic last;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> sv/rea_div.sv
// ----------------------------------------------------------------------------
// rea_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rea_div #(
    parameter int BW  = 51,
    parameter int DVW = 48,
    parameter int SW  = 6
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [BW-1:0]  rem_init,
    input  logic [DVW-1:0] dvd,
    input  logic [BW-1:0]  divisor,
    input  logic [SW-1:0]  steps,
    output logic           done,
    output logic [DVW-1:0] quot
);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [SW-1:0]  cnt_reg, cnt_next;
    logic [BW-1:0]  rem_reg, rem_next;
    logic [DVW-1:0] dvd_reg, dvd_next;
    logic [DVW-1:0] quot_reg, quot_next;
    logic [BW-1:0]  div_reg, div_next;
    logic [BW:0]    trial;
    logic [BW:0]    diff;
    logic           ge;

    // one shift-subtract step
    assign trial = {rem_reg, dvd_reg[DVW-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = rem_init;
            dvd_next  = dvd;
            quot_next = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[BW-1:0] : trial[BW-1:0];
            dvd_next  = {dvd_reg[DVW-2:0], 1'b0};
            quot_next = {quot_reg[DVW-2:0], ge};
            cnt_next  = cnt_reg - SW'(1);
            if (cnt_reg == SW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> sv/rea_dp.sv
// ----------------------------------------------------------------------------
// rea_dp
// Datapath: matrix registers, row products, divides, errors, sums, output.
// ----------------------------------------------------------------------------
module rea_dp #(
    parameter int MAX_POINTS = rea_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = rea_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rea_pkg::ctrl_cmd_t              cmd,
    output rea_pkg::dp_status_t             status,
    input  logic                            cfg_we,
    input  logic [rea_pkg::IDX_W-1:0]       cfg_index,
    input  logic [rea_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    input  logic [rea_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rea_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import rea_pkg::*;

    localparam int ROW_W = 67 - FRAC_BITS;
    localparam int NW    = ROW_W + FRAC_BITS;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int ACC_W = 66;
    localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [SUM_W-1:0]  SUM_MAX = '1;
    localparam logic [ERR_W-1:0]  ERR_MAX = '1;

    // configuration words
    logic [CFG_W-1:0] cfg_reg [NUM_REGS];

    // input item
    logic signed [DATA_W-1:0] mx_reg, my_reg;
    logic signed [DATA_W-1:0] v_reg [3];
    logic                     last_reg;

    // row evaluation
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ROW_W-1:0]    row_reg [3];

    // results
    logic signed [DATA_W-1:0] rx_reg, ry_reg;
    logic [ERR_W-1:0]         ex_reg, ey_reg, ax_reg, ay_reg;
    logic [SUM_W-1:0]         sum_x_reg, sum_y_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     ovf_reg, neg_reg;

    // output register
    logic                     out_valid_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;
    logic                     out_user_reg, out_last_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[0] <= CFG_W'(64'd1 << (FRAC_BITS + 32));
            cfg_reg[1] <= '0;
            cfg_reg[2] <= CFG_W'(64'd1 << FRAC_BITS);
            cfg_reg[3] <= '0;
            cfg_reg[4] <= '0;
            cfg_reg[5] <= CFG_W'(64'd1 << (FRAC_BITS + 32));
        end else if (cfg_we && (cfg_index < IDX_W'(NUM_REGS))) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    // matrix entry select
    logic [IDX_W-1:0]         m_idx;
    logic [IDX_W-1:0]         m3_idx;
    logic signed [DATA_W-1:0] m_sel;
    logic signed [DATA_W-1:0] m3_sel;
    logic signed [DATA_W-1:0] v_sel;

    assign m_idx  = {cmd.row, cmd.col[1]};
    assign m3_idx = {cmd.row, 1'b1};
    assign m_sel  = cmd.col[0] ? $signed(cfg_reg[m_idx][31:0])
                               : $signed(cfg_reg[m_idx][63:32]);
    assign m3_sel = $signed(cfg_reg[m3_idx][31:0]);
    assign v_sel  = v_reg[cmd.col];

    // accumulate; the row is rounded down once, then the offset is added
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_shr;
    assign acc_sum = ((cmd.col == 2'd0) ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
    assign acc_shr = acc_sum >>> FRAC_BITS;

    // divider operands
    logic signed [ROW_W-1:0] num_sel;
    logic [ROW_W-1:0]        num_mag, w_mag;
    logic [NW-1:0]           nshift;
    logic [ROW_W-1:0]        rem_init;
    logic [SUM_W-1:0]        dvd;
    logic [ROW_W-1:0]        divisor;
    logic [STEP_W-1:0]       steps;
    logic                    fx_ovf;
    logic                    div_done;
    logic [SUM_W-1:0]        quot;
    logic                    is_fx;

    assign is_fx   = (cmd.div_op == DIV_RX) || (cmd.div_op == DIV_RY);
    assign num_sel = (cmd.div_op == DIV_RY) ? row_reg[1] : row_reg[0];
    assign num_mag = num_sel[ROW_W-1] ? ROW_W'(-num_sel) : ROW_W'(num_sel);
    assign w_mag   = row_reg[2][ROW_W-1] ? ROW_W'(-row_reg[2]) : ROW_W'(row_reg[2]);
    assign nshift  = {num_mag, {FRAC_BITS{1'b0}}};
    assign fx_ovf  = ROW_W'(nshift[NW-1:QB]) >= w_mag;

    always_comb begin
        if (is_fx) begin
            rem_init = ROW_W'(nshift[NW-1:QB]);
            dvd      = {nshift[QB-1:0], {(SUM_W-QB){1'b0}}};
            divisor  = w_mag;
            steps    = STEP_W'(QB);
        end else begin
            rem_init = '0;
            dvd      = (cmd.div_op == DIV_AY) ? sum_y_reg : sum_x_reg;
            divisor  = ROW_W'(cnt_reg);
            steps    = STEP_W'(SUM_W);
        end
    end

    rea_div #(
        .BW  (ROW_W),
        .DVW (SUM_W),
        .SW  (STEP_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .rem_init (rem_init),
        .dvd      (dvd),
        .divisor  (divisor),
        .steps    (steps),
        .done     (div_done),
        .quot     (quot)
    );

    // projected coordinate from quotient, with zero-depth handling
    logic                    w_zero;
    logic [QB-1:0]           qfx;
    logic signed [DATA_W-1:0] fx_res;
    assign w_zero = (row_reg[2] == '0);
    assign qfx    = quot[QB-1:0];

    always_comb begin
        if (w_zero) begin
            if (num_sel == '0)
                fx_res = '0;
            else
                fx_res = num_sel[ROW_W-1] ? SMIN : SMAX;
        end else if (ovf_reg) begin
            fx_res = neg_reg ? SMIN : SMAX;
        end else if (neg_reg) begin
            fx_res = (qfx >= QB'(34'h080000000)) ? SMIN : -DATA_W'(qfx);
        end else begin
            fx_res = (qfx >= QB'(34'h080000000)) ? SMAX : DATA_W'(qfx);
        end
    end

    logic [ERR_W-1:0] mean_res;
    assign mean_res = (quot > SUM_W'(ERR_MAX)) ? ERR_MAX : quot[ERR_W-1:0];

    // absolute errors and saturating sums
    logic signed [DATA_W:0] dx, dy;
    logic [DATA_W:0]        adx, ady;
    logic [ERR_W-1:0]       ex, ey;
    logic [SUM_W:0]         sx, sy;
    assign dx  = {mx_reg[DATA_W-1], mx_reg} - {rx_reg[DATA_W-1], rx_reg};
    assign dy  = {my_reg[DATA_W-1], my_reg} - {ry_reg[DATA_W-1], ry_reg};
    assign adx = dx[DATA_W] ? (DATA_W+1)'(-dx) : (DATA_W+1)'(dx);
    assign ady = dy[DATA_W] ? (DATA_W+1)'(-dy) : (DATA_W+1)'(dy);
    assign ex  = (adx > (DATA_W+1)'(ERR_MAX)) ? ERR_MAX : adx[ERR_W-1:0];
    assign ey  = (ady > (DATA_W+1)'(ERR_MAX)) ? ERR_MAX : ady[ERR_W-1:0];
    assign sx  = {1'b0, sum_x_reg} + (SUM_W+1)'(ex);
    assign sy  = {1'b0, sum_y_reg} + (SUM_W+1)'(ey);

    // depth saturated to 32 bits
    logic signed [DATA_W-1:0] w_sat;
    always_comb begin
        if (row_reg[2] > ROW_W'($signed(SMAX)))
            w_sat = SMAX;
        else if (row_reg[2] < ROW_W'($signed(SMIN)))
            w_sat = SMIN;
        else
            w_sat = DATA_W'(row_reg[2]);
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            if (cmd.err_update) begin
                sum_x_reg <= sx[SUM_W] ? SUM_MAX : sx[SUM_W-1:0];
                sum_y_reg <= sy[SUM_W] ? SUM_MAX : sy[SUM_W-1:0];
                if (cnt_reg < CNT_W'(MAX_POINTS))
                    cnt_reg <= cnt_reg + CNT_W'(1);
            end
            // sums restart after the mean of the set is taken
            if (cmd.div_store && (cmd.div_op == DIV_AY)) begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                cnt_reg   <= '0;
            end
        end
        if (cmd.load_in) begin
            mx_reg   <= $signed(s_tdata[31:0]);
            my_reg   <= $signed(s_tdata[63:32]);
            v_reg[0] <= $signed(s_tdata[95:64]);
            v_reg[1] <= $signed(s_tdata[127:96]);
            v_reg[2] <= $signed(s_tdata[159:128]);
            last_reg <= s_tlast;
        end
        if (cmd.mul)
            prod_reg <= m_sel * v_sel;
        if (cmd.acc) begin
            acc_reg <= acc_sum;
            if (cmd.col == 2'd2)
                row_reg[cmd.row] <= ROW_W'(acc_shr) + ROW_W'(m3_sel);
        end
        if (cmd.div_start) begin
            ovf_reg <= fx_ovf;
            neg_reg <= num_sel[ROW_W-1] ^ row_reg[2][ROW_W-1];
        end
        if (cmd.div_store) begin
            case (cmd.div_op)
                DIV_RX:  rx_reg <= fx_res;
                DIV_RY:  ry_reg <= fx_res;
                DIV_AX:  ax_reg <= mean_res;
                default: ay_reg <= mean_res;
            endcase
        end
        if (cmd.err_update) begin
            ex_reg <= ex;
            ey_reg <= ey;
            ax_reg <= '0;
            ay_reg <= '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_data_reg <= {4'b0, ay_reg, ax_reg, ey_reg, ex_reg, w_sat, ry_reg, rx_reg};
            out_user_reg <= w_zero;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    assign status.in_valid = s_tvalid;
    assign status.last     = last_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

>>> sv/rea_ctrl.sv
// ----------------------------------------------------------------------------
// rea_ctrl
// Sequencer: row products, four divide slots, error update, output transfer.
// ----------------------------------------------------------------------------
module rea_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rea_pkg::dp_status_t  status,
    output rea_pkg::ctrl_cmd_t   cmd,
    output logic                 in_ready
);
    import rea_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_RX_GO,
        ST_RX_WAIT,
        ST_RY_GO,
        ST_RY_WAIT,
        ST_ERR,
        ST_AX_GO,
        ST_AX_WAIT,
        ST_AY_GO,
        ST_AY_WAIT,
        ST_PUSH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;

    // next state
    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (status.in_valid) begin
                    state_next = ST_MUL;
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                end
            end
            ST_MUL: state_next = ST_ACC;
            ST_ACC: begin
                state_next = ST_MUL;
                if (col_reg == 2'd2) begin
                    col_next = 2'd0;
                    if (row_reg == 2'd2)
                        state_next = ST_RX_GO;
                    else
                        row_next = row_reg + 2'd1;
                end else begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_RX_GO:   state_next = ST_RX_WAIT;
            ST_RX_WAIT: if (status.div_done) state_next = ST_RY_GO;
            ST_RY_GO:   state_next = ST_RY_WAIT;
            ST_RY_WAIT: if (status.div_done) state_next = ST_ERR;
            ST_ERR:     state_next = status.last ? ST_AX_GO : ST_PUSH;
            ST_AX_GO:   state_next = ST_AX_WAIT;
            ST_AX_WAIT: if (status.div_done) state_next = ST_AY_GO;
            ST_AY_GO:   state_next = ST_AY_WAIT;
            ST_AY_WAIT: if (status.div_done) state_next = ST_PUSH;
            ST_PUSH:    if (status.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd            = '0;
        cmd.row        = row_reg;
        cmd.col        = col_reg;
        cmd.div_op     = DIV_RX;
        unique case (state_reg)
            ST_IDLE:    cmd.load_in = status.in_valid;
            ST_MUL:     cmd.mul = 1'b1;
            ST_ACC:     cmd.acc = 1'b1;
            ST_RX_GO:   cmd.div_start = 1'b1;
            ST_RX_WAIT: cmd.div_store = status.div_done;
            ST_RY_GO: begin
                cmd.div_op    = DIV_RY;
                cmd.div_start = 1'b1;
            end
            ST_RY_WAIT: begin
                cmd.div_op    = DIV_RY;
                cmd.div_store = status.div_done;
            end
            ST_ERR:     cmd.err_update = 1'b1;
            ST_AX_GO: begin
                cmd.div_op    = DIV_AX;
                cmd.div_start = 1'b1;
            end
            ST_AX_WAIT: begin
                cmd.div_op    = DIV_AX;
                cmd.div_store = status.div_done;
            end
            ST_AY_GO: begin
                cmd.div_op    = DIV_AY;
                cmd.div_start = 1'b1;
            end
            ST_AY_WAIT: begin
                cmd.div_op    = DIV_AY;
                cmd.div_store = status.div_done;
            end
            ST_PUSH:    cmd.out_load = status.out_free;
            default:    cmd.load_in = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // a divide never finishes the cycle after it starts
    a_div_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !status.div_done)
        else $error("divider finished too early");

    // an accepted item starts the row products
    a_accept_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> (state_reg == ST_MUL && row_reg == 2'd0 && col_reg == 2'd0))
        else $error("accepted item did not start products");

    // the result is loaded only when the output register is free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

endmodule

>>> sv/reprojection_error_accumulator_unit.sv
// ----------------------------------------------------------------------------
// reprojection_error_accumulator_unit
// Projects world points through a 3x4 camera matrix, returns image point,
// depth and errors, and the mean errors at the end of each point set.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata (points), s_tlast (last_point)
//  m_       out  m_tvalid/m_tready  m_tdata (results), m_tuser, m_tlast
//  cfg_     in   cfg_we             cfg_index, cfg_wdata (matrix words)
//
//  An item runs the nine products on one multiplier, then two 34-step divides,
//  and a last point adds two 48-step mean divides; the single serial divider
//  handles every divide in turn.
//  Reset is synchronous, active low; it restores the identity-like matrix.
//  The next item is taken as soon as a result sits in the output register.
// ----------------------------------------------------------------------------
module reprojection_error_accumulator_unit #(
    parameter int MAX_POINTS = rea_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = rea_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rea_pkg::IDX_W-1:0]      cfg_index,
    input  logic [rea_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // meas_x, meas_y, world_x, world_y, world_z
    input  logic [rea_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // reproj_x, reproj_y, depth_w, err_x, err_y, avg_err_x, avg_err_y
    output logic [rea_pkg::M_TDATA_W-1:0]  m_tdata,
    // depth_zero
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import rea_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    rea_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    rea_dp #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
